FILE: hdl/rcca_pkg.sv
// ---------------------------------------------------------------------------
// rcca_pkg
// Shared types and constants of the reorder credit channel arbiter.
// ---------------------------------------------------------------------------
`default_nettype none

package rcca_pkg;

  localparam int THREADS       = 4;
  localparam int CHANNELS      = 4;
  localparam int REORDER_DEPTH = 16;
  localparam int QUEUE_DEPTH   = 64;
  localparam int TAG_BITS      = 8;

  localparam int TH_W    = $clog2(THREADS);
  localparam int CH_W    = $clog2(CHANNELS);
  localparam int SLOT_W  = $clog2(REORDER_DEPTH);
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W  = QPTR_W + 1;
  localparam int SEQ_W   = 16;
  localparam int CNT_W   = 5;
  localparam int STORE_N = THREADS * REORDER_DEPTH;
  localparam int STORE_W = $clog2(STORE_N);
  localparam int QRAM_N  = CHANNELS * QUEUE_DEPTH;
  localparam int QRAM_AW = $clog2(QRAM_N);
  localparam int BUF_N   = 3;

  localparam logic [CNT_W-1:0] MAX_ACTIVE_RST = CNT_W'(16);
  localparam logic [SEQ_W-1:0] SEQ_RST        = SEQ_W'(1);

  typedef enum logic [1:0] {
    CMD_REQ_BEGIN  = 2'd0,
    CMD_REQ_ACCEPT = 2'd1,
    CMD_RSP_BEGIN  = 2'd2,
    CMD_RSP_ACCEPT = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_REQ_ACC = 2'd0,
    KIND_ISSUE   = 2'd1,
    KIND_RSP_ACC = 2'd2,
    KIND_RSP_RET = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ROUTE,
    ST_QOUT,
    ST_RET_RD,
    ST_RET_OUT,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    kind_e                kind;
    logic [TAG_BITS-1:0]  tag;
    logic [TH_W-1:0]      th;
    logic [CH_W-1:0]      ch;
    logic [SEQ_W-1:0]     seq;
  } result_t;

  typedef struct packed {
    logic latch;
    logic accept;
    logic use_held;
    logic hold;
    logic inc_cnt;
    logic dec_cnt;
    logic qpop_out;
    logic clr_busy;
    logic resp_in;
    logic route;
    logic ret_out;
    logic clr_resp_busy;
    logic drain;
  } ctrl_t;

  typedef struct packed {
    cmd_e cmd;
    logic cnt_below;
    logic held_v;
    logic resp_busy;
    logic slot_valid;
    logic q_nonempty;
    logic buf_empty;
  } stat_t;

endpackage

`default_nettype wire

FILE: hdl/rcca_in_if.sv
// ---------------------------------------------------------------------------
// rcca_in_if
// Event channel: valid/ready handshake with the event fields.
// ---------------------------------------------------------------------------
`default_nettype none

interface rcca_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  tag;
  logic [1:0]  thread;
  logic [1:0]  channel;
  logic [15:0] seq_id;

  modport source (output valid, cmd, tag, thread, channel, seq_id, input ready);
  modport sink   (input valid, cmd, tag, thread, channel, seq_id, output ready);
endinterface

`default_nettype wire

FILE: hdl/rcca_out_if.sv
// ---------------------------------------------------------------------------
// rcca_out_if
// Result channel: valid/ready handshake with the result fields.
// ---------------------------------------------------------------------------
`default_nettype none

interface rcca_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_tag;
  logic [1:0]  out_thread;
  logic [1:0]  out_channel;
  logic [15:0] out_seq;
  logic        last;

  modport source (output valid, kind, out_tag, out_thread, out_channel, out_seq, last,
                  input ready);
  modport sink   (input valid, kind, out_tag, out_thread, out_channel, out_seq, last,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/reorder_credit_channel_arbiter_core.sv
// An event is sequenced through its actions, with a further state for each
// queue or reorder memory read; its result words are then moved one by one
// to the output register as it frees, until the buffer is found empty.
// One event is in work at a time.
// Reset is asynchronous active low: counters, flags, queue pointers and
// reorder valid bits clear at once; max_active returns to 16.
// ---------------------------------------------------------------------------
// reorder_credit_channel_arbiter_core
// Routes thread requests to channels and returns responses in order.
// ---------------------------------------------------------------------------
`default_nettype none

module reorder_credit_channel_arbiter_core import rcca_pkg::*; (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              cfg_we_i,
  input  wire [CNT_W-1:0]  cfg_wdata_i,
  rcca_in_if.sink          in_i,
  rcca_out_if.source       out_o
);

  ctrl_t ctrl;
  stat_t stat;

  rcca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  rcca_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .in_i        (in_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

FILE: hdl/rcca_ram.sv
// ---------------------------------------------------------------------------
// rcca_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module rcca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(DEPTH)-1:0]  waddr_i,
  input  wire [WIDTH-1:0]          wdata_i,
  input  wire [$clog2(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hdl/rcca_ctrl.sv
// ---------------------------------------------------------------------------
// rcca_ctrl
// Event sequencer: steps one event through its actions, then drains results.
// ---------------------------------------------------------------------------
`default_nettype none

module rcca_ctrl import rcca_pkg::*; (
  input  wire    clk_i,
  input  wire    rst_ni,
  input  wire    in_valid_i,
  output logic   in_ready_o,
  input  stat_t  stat_i,
  output ctrl_t  ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (stat_i.cmd)
          CMD_REQ_BEGIN:  state_d = stat_i.cnt_below ? ST_ROUTE : ST_DRAIN;
          CMD_REQ_ACCEPT: state_d = stat_i.q_nonempty ? ST_QOUT : ST_DRAIN;
          CMD_RSP_BEGIN:  state_d = stat_i.resp_busy ? ST_DRAIN : ST_RET_RD;
          CMD_RSP_ACCEPT: state_d = stat_i.held_v ? ST_ROUTE : ST_RET_RD;
          default:        state_d = ST_DRAIN;
        endcase
      end
      ST_ROUTE:   state_d = (stat_i.cmd == CMD_RSP_ACCEPT) ? ST_RET_RD : ST_DRAIN;
      ST_QOUT:    state_d = ST_DRAIN;
      ST_RET_RD:  state_d = stat_i.slot_valid ? ST_RET_OUT : ST_DRAIN;
      ST_RET_OUT: state_d = ST_DRAIN;
      ST_DRAIN: begin
        if (stat_i.buf_empty) state_d = ST_IDLE;
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        ctrl_o.latch = in_valid_i;
      end
      ST_EXEC: begin
        unique case (stat_i.cmd)
          CMD_REQ_BEGIN: begin
            if (stat_i.cnt_below) begin
              ctrl_o.inc_cnt = 1'b1;
              ctrl_o.accept  = 1'b1;
            end else begin
              ctrl_o.hold = 1'b1;
            end
          end
          CMD_REQ_ACCEPT: begin
            if (!stat_i.q_nonempty) ctrl_o.clr_busy = 1'b1;
          end
          CMD_RSP_BEGIN: ctrl_o.resp_in = 1'b1;
          CMD_RSP_ACCEPT: begin
            if (stat_i.held_v) begin
              ctrl_o.accept   = 1'b1;
              ctrl_o.use_held = 1'b1;
            end else begin
              ctrl_o.dec_cnt = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_ROUTE: ctrl_o.route = 1'b1;
      ST_QOUT:  ctrl_o.qpop_out = 1'b1;
      ST_RET_RD: begin
        if (!stat_i.slot_valid && stat_i.cmd == CMD_RSP_ACCEPT) ctrl_o.clr_resp_busy = 1'b1;
      end
      ST_RET_OUT: ctrl_o.ret_out = 1'b1;
      ST_DRAIN:   ctrl_o.drain = 1'b1;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/rcca_dp.sv
// ---------------------------------------------------------------------------
// rcca_dp
// Datapath: per-thread and per-channel state, queue and reorder memories,
// result buffer and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module rcca_dp import rcca_pkg::*; (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             cfg_we_i,
  input  wire [CNT_W-1:0] cfg_wdata_i,
  input  ctrl_t           ctrl_i,
  output stat_t           stat_o,
  rcca_in_if.sink         in_i,
  rcca_out_if.source      out_o
);

  localparam int QW = TAG_BITS + TH_W + SEQ_W;
  localparam int SW = TAG_BITS + CH_W;

  // latched event
  cmd_e                cmd_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [TH_W-1:0]     th_q;
  logic [CH_W-1:0]     ch_q;
  logic [SEQ_W-1:0]    sid_q;
  logic [SEQ_W-1:0]    seq_q;

  logic [CNT_W-1:0]    max_q;
  logic [CNT_W-1:0]    cnt_q      [THREADS];
  logic                held_v_q   [THREADS];
  logic [TAG_BITS-1:0] held_tag_q [THREADS];
  logic [CH_W-1:0]     held_ch_q  [THREADS];
  logic [SEQ_W-1:0]    nseq_q     [THREADS];
  logic [SEQ_W-1:0]    rseq_q     [THREADS];
  logic                rbusy_q    [THREADS];
  logic                svalid_q   [STORE_N];
  logic                cbusy_q    [CHANNELS];
  logic [QPTR_W-1:0]   qhead_q    [CHANNELS];
  logic [QCNT_W-1:0]   qcnt_q     [CHANNELS];

  result_t             buf_q [BUF_N];
  logic [1:0]          bwr_q, brd_q, bcnt_q;
  logic                out_valid_q, out_last_q;
  result_t             out_q;

  // memories
  logic                q_we;
  logic [QRAM_AW-1:0]  q_waddr, q_raddr;
  logic [QW-1:0]       q_wdata, q_rdata;
  logic                s_we;
  logic [STORE_W-1:0]  s_waddr, s_raddr;
  logic [SW-1:0]       s_rdata;

  logic                push;
  result_t             push_r;
  logic [TAG_BITS-1:0] acc_tag;
  logic [CH_W-1:0]     acc_ch;
  logic [SEQ_W-1:0]    seq_gap;
  logic                out_free;
  logic [QPTR_W-1:0]   q_tail;

  assign acc_tag  = ctrl_i.use_held ? held_tag_q[th_q] : tag_q;
  assign acc_ch   = ctrl_i.use_held ? held_ch_q[th_q]  : ch_q;
  assign seq_gap  = sid_q - rseq_q[th_q];
  assign out_free = !out_valid_q || out_o.ready;
  assign q_tail   = qhead_q[ch_q] + qcnt_q[ch_q][QPTR_W-1:0];

  assign q_raddr = {ch_q, qhead_q[ch_q]};
  assign q_waddr = {ch_q, q_tail};
  assign q_wdata = {tag_q, th_q, seq_q};
  assign q_we    = ctrl_i.route && cbusy_q[ch_q] && (qcnt_q[ch_q] < QCNT_W'(QUEUE_DEPTH));

  assign s_waddr = {th_q, sid_q[SLOT_W-1:0]};
  assign s_raddr = {th_q, rseq_q[th_q][SLOT_W-1:0]};
  assign s_we    = ctrl_i.resp_in && (seq_gap < SEQ_W'(REORDER_DEPTH));

  rcca_ram #(.WIDTH(QW), .DEPTH(QRAM_N)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  rcca_ram #(.WIDTH(SW), .DEPTH(STORE_N)) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i ({tag_q, ch_q}),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  // at most one result is produced per step
  always_comb begin
    push   = 1'b0;
    push_r = '0;
    if (ctrl_i.accept) begin
      push   = 1'b1;
      push_r = '{kind: KIND_REQ_ACC, tag: acc_tag, th: th_q, ch: acc_ch, seq: nseq_q[th_q]};
    end else if (ctrl_i.route && !cbusy_q[ch_q]) begin
      push   = 1'b1;
      push_r = '{kind: KIND_ISSUE, tag: tag_q, th: th_q, ch: ch_q, seq: seq_q};
    end else if (ctrl_i.qpop_out) begin
      push   = 1'b1;
      push_r = '{kind: KIND_ISSUE, tag: q_rdata[QW-1 -: TAG_BITS],
                 th: q_rdata[SEQ_W +: TH_W], ch: ch_q, seq: q_rdata[SEQ_W-1:0]};
    end else if (ctrl_i.resp_in) begin
      push   = 1'b1;
      push_r = '{kind: KIND_RSP_ACC, tag: tag_q, th: th_q, ch: ch_q, seq: sid_q};
    end else if (ctrl_i.ret_out) begin
      push   = 1'b1;
      push_r = '{kind: KIND_RSP_RET, tag: s_rdata[SW-1 -: TAG_BITS], th: th_q,
                 ch: s_rdata[CH_W-1:0], seq: rseq_q[th_q]};
    end
  end

  always_comb begin
    stat_o.cmd        = cmd_q;
    stat_o.cnt_below  = cnt_q[th_q] < max_q;
    stat_o.held_v     = held_v_q[th_q];
    stat_o.resp_busy  = rbusy_q[th_q];
    stat_o.slot_valid = svalid_q[s_raddr];
    stat_o.q_nonempty = qcnt_q[ch_q] != '0;
    stat_o.buf_empty  = bcnt_q == '0;
  end

  // event and result payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      cmd_q <= cmd_e'(in_i.cmd);
      tag_q <= in_i.tag;
      th_q  <= in_i.thread;
      ch_q  <= in_i.channel;
      sid_q <= in_i.seq_id;
    end
    if (ctrl_i.accept) begin
      tag_q <= acc_tag;
      ch_q  <= acc_ch;
      seq_q <= nseq_q[th_q];
    end
    if (ctrl_i.hold) begin
      held_tag_q[th_q] <= tag_q;
      held_ch_q[th_q]  <= ch_q;
    end
    if (push) begin
      buf_q[bwr_q] <= push_r;
    end
    if (ctrl_i.drain && bcnt_q != '0 && out_free) begin
      out_q      <= buf_q[brd_q];
      out_last_q <= bcnt_q == 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= MAX_ACTIVE_RST;
      bwr_q       <= '0;
      brd_q       <= '0;
      bcnt_q      <= '0;
      out_valid_q <= 1'b0;
      for (int t = 0; t < THREADS; t++) begin
        cnt_q[t]    <= '0;
        held_v_q[t] <= 1'b0;
        nseq_q[t]   <= SEQ_RST;
        rseq_q[t]   <= SEQ_RST;
        rbusy_q[t]  <= 1'b0;
      end
      for (int s = 0; s < STORE_N; s++) begin
        svalid_q[s] <= 1'b0;
      end
      for (int c = 0; c < CHANNELS; c++) begin
        cbusy_q[c] <= 1'b0;
        qhead_q[c] <= '0;
        qcnt_q[c]  <= '0;
      end
    end else begin
      if (cfg_we_i) max_q <= cfg_wdata_i;
      if (ctrl_i.inc_cnt) cnt_q[th_q] <= cnt_q[th_q] + CNT_W'(1);
      if (ctrl_i.dec_cnt && cnt_q[th_q] != '0) cnt_q[th_q] <= cnt_q[th_q] - CNT_W'(1);
      if (ctrl_i.hold) held_v_q[th_q] <= 1'b1;
      if (ctrl_i.accept) begin
        nseq_q[th_q] <= nseq_q[th_q] + SEQ_W'(1);
        if (ctrl_i.use_held) held_v_q[th_q] <= 1'b0;
      end
      if (ctrl_i.route) begin
        if (!cbusy_q[ch_q]) begin
          cbusy_q[ch_q] <= 1'b1;
        end else if (q_we) begin
          qcnt_q[ch_q] <= qcnt_q[ch_q] + QCNT_W'(1);
        end
      end
      if (ctrl_i.qpop_out) begin
        qhead_q[ch_q] <= qhead_q[ch_q] + QPTR_W'(1);
        qcnt_q[ch_q]  <= qcnt_q[ch_q] - QCNT_W'(1);
      end
      if (ctrl_i.clr_busy) cbusy_q[ch_q] <= 1'b0;
      if (s_we) svalid_q[s_waddr] <= 1'b1;
      if (ctrl_i.ret_out) begin
        svalid_q[s_raddr] <= 1'b0;
        rseq_q[th_q]      <= rseq_q[th_q] + SEQ_W'(1);
        rbusy_q[th_q]     <= 1'b1;
      end
      if (ctrl_i.clr_resp_busy) rbusy_q[th_q] <= 1'b0;

      // result buffer, filled during the event and drained after it
      if (push) begin
        bwr_q  <= (bwr_q == 2'(BUF_N - 1)) ? 2'd0 : bwr_q + 2'd1;
        bcnt_q <= bcnt_q + 2'd1;
      end
      if (ctrl_i.drain && bcnt_q != '0 && out_free) begin
        brd_q       <= (brd_q == 2'(BUF_N - 1)) ? 2'd0 : brd_q + 2'd1;
        bcnt_q      <= bcnt_q - 2'd1;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_q.kind;
  assign out_o.out_tag     = out_q.tag;
  assign out_o.out_thread  = out_q.th;
  assign out_o.out_channel = out_q.ch;
  assign out_o.out_seq     = out_q.seq;
  assign out_o.last        = out_last_q;

endmodule

`default_nettype wire

FILE: tb/sv/rcca_order_checker.sv
// ---------------------------------------------------------------------------
// rcca_order_checker
// Watches the event and result channels of the reorder arbiter, predicts the
// result words of every accepted event and compares them in order.
// ---------------------------------------------------------------------------
`default_nettype none

module rcca_order_checker import rcca_pkg::*; (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              cfg_we_i,
  input  wire [CNT_W-1:0]  cfg_wdata_i,
  rcca_in_if               ev_mon,
  rcca_out_if              res_mon,
  output int               mismatches_o,
  output int               pending_o
);

  typedef struct {
    kind_e       kind;
    logic [7:0]  tag;
    logic [1:0]  th;
    logic [1:0]  ch;
    logic [15:0] seq;
    logic        last;
  } word_t;

  word_t expected_words[$];

  logic [CNT_W-1:0] max_active;
  logic [CNT_W-1:0] active_cnt [THREADS];
  logic             held_v     [THREADS];
  logic [7:0]       held_tag   [THREADS];
  logic [1:0]       held_ch    [THREADS];
  logic [15:0]      next_seq   [THREADS];
  logic [15:0]      ret_seq    [THREADS];
  logic             resp_busy  [THREADS];
  logic             slot_v     [STORE_N];
  logic [7:0]       slot_tag   [STORE_N];
  logic [1:0]       slot_ch    [STORE_N];
  logic             ch_busy    [CHANNELS];
  logic [7:0]       q_tag      [CHANNELS][QUEUE_DEPTH];
  logic [1:0]       q_th       [CHANNELS][QUEUE_DEPTH];
  logic [15:0]      q_seq      [CHANNELS][QUEUE_DEPTH];
  int               q_head     [CHANNELS];
  int               q_cnt      [CHANNELS];

  task automatic push_word(kind_e k, logic [7:0] tag, logic [1:0] th, logic [1:0] ch,
                           logic [15:0] seq);
    word_t w;
    w.kind = k; w.tag = tag; w.th = th; w.ch = ch; w.seq = seq; w.last = 1'b0;
    expected_words.push_back(w);
  endtask

  task automatic grant_request(logic [7:0] tag, logic [1:0] th, logic [1:0] ch);
    logic [15:0] s;
    int          pos;
    s = next_seq[th];
    next_seq[th] = s + 16'd1;
    push_word(KIND_REQ_ACC, tag, th, ch, s);
    if (!ch_busy[ch]) begin
      ch_busy[ch] = 1'b1;
      push_word(KIND_ISSUE, tag, th, ch, s);
    end else if (q_cnt[ch] < QUEUE_DEPTH) begin
      pos = (q_head[ch] + q_cnt[ch]) % QUEUE_DEPTH;
      q_tag[ch][pos] = tag;
      q_th[ch][pos]  = th;
      q_seq[ch][pos] = s;
      q_cnt[ch]++;
    end
    // queue full: the request is granted but silently dropped
  endtask

  function automatic int slot_of(logic [1:0] th, logic [15:0] s);
    return th * REORDER_DEPTH + s % REORDER_DEPTH;
  endfunction

  task automatic return_next(logic [1:0] th, output logic sent);
    int sl;
    sl = slot_of(th, ret_seq[th]);
    sent = slot_v[sl];
    if (sent) begin
      slot_v[sl] = 1'b0;
      push_word(KIND_RSP_RET, slot_tag[sl], th, slot_ch[sl], ret_seq[th]);
      ret_seq[th] = ret_seq[th] + 16'd1;
      resp_busy[th] = 1'b1;
    end
  endtask

  task automatic predict_event(cmd_e cmd, logic [7:0] tag, logic [1:0] th, logic [1:0] ch,
                               logic [15:0] sid);
    int          before_n;
    int          pos;
    int          sl;
    logic [15:0] seq_gap;
    logic        sent;
    before_n = expected_words.size();
    case (cmd)
      CMD_REQ_BEGIN: begin
        if (active_cnt[th] < max_active) begin
          active_cnt[th]++;
          grant_request(tag, th, ch);
        end else begin
          held_v[th] = 1'b1; held_tag[th] = tag; held_ch[th] = ch;
        end
      end
      CMD_REQ_ACCEPT: begin
        if (q_cnt[ch] > 0) begin
          pos = q_head[ch];
          push_word(KIND_ISSUE, q_tag[ch][pos], q_th[ch][pos], ch, q_seq[ch][pos]);
          q_head[ch] = (pos + 1) % QUEUE_DEPTH;
          q_cnt[ch]--;
        end else begin
          ch_busy[ch] = 1'b0;
        end
      end
      CMD_RSP_BEGIN: begin
        seq_gap = sid - ret_seq[th];
        push_word(KIND_RSP_ACC, tag, th, ch, sid);
        if (seq_gap < REORDER_DEPTH) begin
          sl = slot_of(th, sid);
          slot_v[sl] = 1'b1; slot_tag[sl] = tag; slot_ch[sl] = ch;
        end
        if (!resp_busy[th]) return_next(th, sent);
      end
      default: begin
        if (held_v[th]) begin
          held_v[th] = 1'b0;
          grant_request(held_tag[th], th, held_ch[th]);
        end else if (active_cnt[th] > 0) begin
          active_cnt[th]--;
        end
        return_next(th, sent);
        if (!sent) resp_busy[th] = 1'b0;
      end
    endcase
    if (expected_words.size() > before_n)
      expected_words[expected_words.size()-1].last = 1'b1;
  endtask

  task automatic report(string what, word_t e);
    if (mismatches_o < 10) begin
      $write("%0t: %s exp kind=%0d tag=%0h th=%0d ch=%0d seq=%0h last=%0b",
             $realtime, what, e.kind, e.tag, e.th, e.ch, e.seq, e.last);
      $display(" | act kind=%0d tag=%0h th=%0d ch=%0d seq=%0h last=%0b",
               res_mon.kind, res_mon.out_tag, res_mon.out_thread, res_mon.out_channel,
               res_mon.out_seq, res_mon.last);
    end
    mismatches_o++;
  endtask

  initial mismatches_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    word_t e;
    if (!rst_ni) begin
      max_active = MAX_ACTIVE_RST;
      for (int i = 0; i < THREADS; i++) begin
        active_cnt[i] = '0; held_v[i] = 1'b0; held_tag[i] = '0; held_ch[i] = '0;
        next_seq[i] = SEQ_RST; ret_seq[i] = SEQ_RST; resp_busy[i] = 1'b0;
      end
      for (int i = 0; i < STORE_N; i++) slot_v[i] = 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        ch_busy[i] = 1'b0; q_head[i] = 0; q_cnt[i] = 0;
      end
      expected_words.delete();
    end else begin
      if (cfg_we_i) max_active = cfg_wdata_i;
      if (ev_mon.valid && ev_mon.ready)
        predict_event(cmd_e'(ev_mon.cmd), ev_mon.tag, ev_mon.thread, ev_mon.channel,
                      ev_mon.seq_id);
      if (res_mon.valid && res_mon.ready) begin
        if (expected_words.size() == 0) begin
          e = '{KIND_REQ_ACC, 8'h0, 2'h0, 2'h0, 16'h0, 1'b0};
          report("unexpected word", e);
        end else begin
          e = expected_words.pop_front();
          if (res_mon.kind != e.kind || res_mon.out_tag != e.tag ||
              res_mon.out_thread != e.th || res_mon.out_channel != e.ch ||
              res_mon.out_seq != e.seq || res_mon.last != e.last)
            report("word mismatch", e);
        end
      end
    end
    pending_o = expected_words.size();
  end

endmodule

`default_nettype wire

FILE: tb/sv/tb_reorder_credit_channel_arbiter_core.sv
// ---------------------------------------------------------------------------
// tb_reorder_credit_channel_arbiter_core
// Drives directed and random handshake events into the arbiter under several
// in-flight limits, with random gaps and output stalls; the checker beside
// the block predicts and compares every result word.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_reorder_credit_channel_arbiter_core;
  import rcca_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 52;

  typedef struct {
    logic [7:0]  tag;
    logic [1:0]  th;
    logic [1:0]  ch;
    logic [15:0] seq;
  } issued_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;
  logic             no_stall;
  int               mismatches;
  int               pending;
  int               quiet_cycles;
  issued_t          issued_pool[$];
  logic [CNT_W-1:0] limits [5] = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd4};

  rcca_in_if  ev_if ();
  rcca_out_if res_if ();

  reorder_credit_channel_arbiter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (ev_if),
    .out_o       (res_if)
  );

  rcca_order_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .ev_mon       (ev_if),
    .res_mon      (res_if),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // output stalls
  always @(posedge clk_i) begin
    res_if.ready <= no_stall || ($urandom_range(0, 99) >= 6);
  end

  // keep issued requests so responses can name real sequence numbers
  always @(posedge clk_i) begin
    issued_t it;
    if (res_if.valid && res_if.ready && res_if.kind == KIND_ISSUE) begin
      it.tag = res_if.out_tag; it.th = res_if.out_thread;
      it.ch = res_if.out_channel; it.seq = res_if.out_seq;
      issued_pool.push_back(it);
    end
  end

  always @(posedge clk_i) begin
    if ((ev_if.valid && ev_if.ready) || (res_if.valid && res_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_event(cmd_e cmd, logic [7:0] tag, logic [1:0] th, logic [1:0] ch,
                            logic [15:0] sid);
    logic hit;
    if (!no_stall) begin
      while ($urandom_range(0, 99) < 6) begin
        ev_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    ev_if.valid   <= 1'b1;
    ev_if.cmd     <= cmd;
    ev_if.tag     <= tag;
    ev_if.thread  <= th;
    ev_if.channel <= ch;
    ev_if.seq_id  <= sid;
    do begin
      @(negedge clk_i);
      hit = ev_if.ready;
      @(posedge clk_i);
    end while (!hit);
  endtask

  task automatic drain_and_settle();
    ev_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [CNT_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_event();
    int      pick;
    int      idx;
    issued_t it;
    pick = $urandom_range(0, 99);
    if (pick < 30 || (pick < 75 && pick >= 50 && issued_pool.size() == 0))
      send_event(CMD_REQ_BEGIN, 8'($urandom), 2'($urandom), 2'($urandom), 16'($urandom));
    else if (pick < 50)
      send_event(CMD_REQ_ACCEPT, 8'($urandom), 2'($urandom), 2'($urandom), 16'($urandom));
    else if (pick < 75) begin
      if ($urandom_range(0, 99) < 85) begin
        idx = $urandom_range(0, issued_pool.size() - 1);
        it = issued_pool[idx];
        issued_pool.delete(idx);
        send_event(CMD_RSP_BEGIN, 8'($urandom), it.th, it.ch, it.seq);
      end else begin
        send_event(CMD_RSP_BEGIN, 8'($urandom), 2'($urandom), 2'($urandom), 16'($urandom));
      end
    end else
      send_event(CMD_RSP_ACCEPT, 8'($urandom), 2'($urandom), 2'($urandom), 16'($urandom));
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    no_stall      = 1'b0;
    quiet_cycles  = 0;
    ev_if.valid   = 1'b0;
    ev_if.cmd     = CMD_REQ_BEGIN;
    ev_if.tag     = '0;
    ev_if.thread  = '0;
    ev_if.channel = '0;
    ev_if.seq_id  = '0;
    res_if.ready  = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle channel accept, thread accept with nothing in flight, then three requests and a channel accept
    send_event(CMD_REQ_ACCEPT, 8'h00, 2'd0, 2'd0, 16'h0000);
    send_event(CMD_RSP_ACCEPT, 8'h00, 2'd0, 2'd0, 16'h0000);
    send_event(CMD_REQ_BEGIN,  8'h00, 2'd0, 2'd0, 16'h0000);
    send_event(CMD_REQ_BEGIN,  8'hFF, 2'd3, 2'd3, 16'hFFFF);
    send_event(CMD_REQ_BEGIN,  8'h5A, 2'd0, 2'd0, 16'h0000);
    send_event(CMD_REQ_ACCEPT, 8'h00, 2'd0, 2'd0, 16'h0000);
    // out of order, then the missing one, then far ahead
    send_event(CMD_RSP_BEGIN,  8'h5A, 2'd0, 2'd0, 16'd2);
    send_event(CMD_RSP_BEGIN,  8'h00, 2'd0, 2'd0, 16'd1);
    send_event(CMD_RSP_BEGIN,  8'hA5, 2'd0, 2'd1, 16'hFFFF);
    send_event(CMD_RSP_BEGIN,  8'hFF, 2'd3, 2'd3, 16'd1);
    send_event(CMD_RSP_ACCEPT, 8'h00, 2'd0, 2'd0, 16'h0000);
    send_event(CMD_RSP_ACCEPT, 8'h00, 2'd0, 2'd0, 16'h0000);
    // slot written twice
    send_event(CMD_RSP_BEGIN,  8'h11, 2'd0, 2'd2, 16'd3);
    send_event(CMD_RSP_BEGIN,  8'hAA, 2'd0, 2'd2, 16'd3);
    drain_and_settle();

    // limit of one: hold, overwrite the held request, release it
    write_limit(5'd1);
    send_event(CMD_REQ_BEGIN,  8'h21, 2'd1, 2'd1, 16'h0);
    send_event(CMD_REQ_BEGIN,  8'h22, 2'd1, 2'd2, 16'h0);
    send_event(CMD_REQ_BEGIN,  8'h23, 2'd1, 2'd3, 16'h0);
    send_event(CMD_RSP_ACCEPT, 8'h00, 2'd1, 2'd0, 16'h0);
    send_event(CMD_RSP_ACCEPT, 8'h00, 2'd2, 2'd0, 16'h0);
    drain_and_settle();

    for (int p = 0; p < 5; p++) begin
      write_limit(limits[p]);
      no_stall = (p == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) random_event();
      drain_and_settle();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
hdl/rcca_pkg.sv
hdl/rcca_in_if.sv
hdl/rcca_out_if.sv
hdl/rcca_ram.sv
hdl/rcca_ctrl.sv
hdl/rcca_dp.sv
hdl/reorder_credit_channel_arbiter_core.sv
tb/sv/rcca_order_checker.sv
tb/sv/tb_reorder_credit_channel_arbiter_core.sv
